FILE: hdl/sahp_pkg.sv
// Shared types and constants for the stepper axis homing positioner.
// No dependencies; every other file refers to this package by scoped names.
package sahp_pkg;

   localparam int POS_BITS = 16;
   localparam int DBN_BITS = 4;

   localparam logic [POS_BITS-1:0] TRAVEL_RESET   = 16'd2800;
   localparam logic [DBN_BITS-1:0] DEBOUNCE_RESET = 4'd3;

   typedef enum logic [0:0] {
      CSR_TRAVEL   = 1'b0,
      CSR_DEBOUNCE = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_TICK = 1'b0,
      CMD_MOVE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      MODE_SEEK    = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_READY   = 2'd2,
      MODE_MOVING  = 2'd3
   } axis_mode_type;

   typedef enum logic [1:0] {
      STAT_NONE      = 2'd0,
      STAT_ACCEPTED  = 2'd1,
      STAT_NOT_READY = 2'd2,
      STAT_RANGE     = 2'd3
   } req_status_type;

   typedef enum logic [1:0] {
      EVT_NONE   = 2'd0,
      EVT_TARGET = 2'd1,
      EVT_UPPER  = 2'd2,
      EVT_LOWER  = 2'd3
   } motion_event_type;

   typedef struct packed {
      logic                command;
      logic                switch_level;
      logic [POS_BITS-1:0] target_position;
   } req_type;

   typedef struct packed {
      logic                step_pulse;
      logic                step_direction;
      logic                driver_enable;
      logic [POS_BITS-1:0] position;
      axis_mode_type       axis_mode;
      logic                switch_stable;
      req_status_type      request_status;
      motion_event_type    motion_event;
   } rsp_type;

endpackage

FILE: hdl/sahp_debounce.sv
// Home switch debouncer: run-length count of equal raw samples.
// Depends on sahp_pkg.
module sahp_debounce (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         sample,
   input  logic                         raw_level,
   input  logic [sahp_pkg::DBN_BITS-1:0] debounce_ticks,
   output logic                         level_next
);

   logic                          last_ff, last_in;
   logic [sahp_pkg::DBN_BITS-1:0] run_ff, run_in;
   logic                          stable_ff, stable_in;

   always_comb begin
      if (raw_level == last_ff) begin
         run_in = (run_ff < debounce_ticks) ? run_ff + 1'b1 : run_ff;
      end else begin
         run_in = '0;
      end
      stable_in = (run_in >= debounce_ticks) ? raw_level : stable_ff;
      last_in   = raw_level;
   end

   assign level_next = sample ? stable_in : stable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= 1'b0;
         run_ff    <= '0;
         stable_ff <= 1'b0;
      end else if (sample) begin
         last_ff   <= last_in;
         run_ff    <= run_in;
         stable_ff <= stable_in;
      end
   end

endmodule

FILE: hdl/sahp_axis.sv
// Axis mode machine and position datapath; produces the result for one item.
// Depends on sahp_pkg.
module sahp_axis (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  sahp_pkg::req_type             req,
   input  logic                          level_next,
   input  logic [sahp_pkg::POS_BITS-1:0] travel_steps,
   output sahp_pkg::rsp_type             result
);

   localparam int PW = sahp_pkg::POS_BITS;
   localparam logic signed [PW+1:0] STEP_ONE = (PW+2)'(1);

   sahp_pkg::axis_mode_type mode_ff, mode_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic [PW-1:0]           target_ff, target_in;
   logic                    dir_ff, dir_in;
   logic                    en_ff, en_in;

   logic                        pulse;
   sahp_pkg::req_status_type    status;
   sahp_pkg::motion_event_type  evt;

   logic [PW-1:0]        home_target;
   logic signed [PW+1:0] step_pos, travel_w, clamp_hi, clamp_lo;
   logic                 hit_upper, hit_lower, hit_target, move_stop;
   logic [PW-1:0]        move_pos;
   sahp_pkg::motion_event_type move_evt;
   logic                 is_tick, req_in_range, req_same;

   assign home_target  = travel_steps >> 1;
   assign is_tick      = (req.command == sahp_pkg::CMD_TICK);
   assign req_in_range = (req.target_position <= travel_steps);
   assign req_same     = (req.target_position == pos_ff);

   // one step with clamping: upper end first, then lower end, target wins the event
   always_comb begin
      travel_w   = $signed({2'b00, travel_steps});
      step_pos   = dir_ff ? $signed({2'b00, pos_ff}) - STEP_ONE
                          : $signed({2'b00, pos_ff}) + STEP_ONE;
      hit_upper  = (step_pos >= travel_w);
      clamp_hi   = hit_upper ? travel_w : step_pos;
      hit_lower  = (clamp_hi <= 0);
      clamp_lo   = hit_lower ? '0 : clamp_hi;
      move_pos   = clamp_lo[PW-1:0];
      hit_target = (clamp_lo == $signed({2'b00, target_ff}));
      move_stop  = hit_upper | hit_lower | hit_target;
      if (hit_target) begin
         move_evt = sahp_pkg::EVT_TARGET;
      end else if (hit_lower) begin
         move_evt = sahp_pkg::EVT_LOWER;
      end else if (hit_upper) begin
         move_evt = sahp_pkg::EVT_UPPER;
      end else begin
         move_evt = sahp_pkg::EVT_NONE;
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      if (is_tick) begin
         unique case (mode_ff)
            sahp_pkg::MODE_SEEK: begin
               if (level_next) mode_in = sahp_pkg::MODE_RELEASE;
            end
            sahp_pkg::MODE_RELEASE: begin
               if (!level_next) begin
                  mode_in = (home_target == '0) ? sahp_pkg::MODE_READY
                                                : sahp_pkg::MODE_MOVING;
               end
            end
            sahp_pkg::MODE_MOVING: begin
               if (move_stop) mode_in = sahp_pkg::MODE_READY;
            end
            default: mode_in = mode_ff;
         endcase
      end else if (mode_ff == sahp_pkg::MODE_READY && req_in_range && !req_same) begin
         mode_in = sahp_pkg::MODE_MOVING;
      end
   end

   // datapath and result fields
   always_comb begin
      pos_in    = pos_ff;
      target_in = target_ff;
      dir_in    = dir_ff;
      en_in     = en_ff;
      pulse     = 1'b0;
      status    = sahp_pkg::STAT_NONE;
      evt       = sahp_pkg::EVT_NONE;
      if (is_tick) begin
         unique case (mode_ff)
            sahp_pkg::MODE_SEEK: begin
               pulse = 1'b1;
            end
            sahp_pkg::MODE_RELEASE: begin
               pulse = 1'b1;
               if (!level_next) begin
                  pos_in    = '0;
                  dir_in    = 1'b0;
                  target_in = home_target;
                  en_in     = (home_target != '0);
                  evt       = (home_target == '0) ? sahp_pkg::EVT_TARGET
                                                  : sahp_pkg::EVT_NONE;
               end
            end
            sahp_pkg::MODE_MOVING: begin
               pulse  = 1'b1;
               pos_in = move_pos;
               if (move_stop) en_in = 1'b0;
               evt    = move_evt;
            end
            default: pulse = 1'b0;
         endcase
      end else if (mode_ff != sahp_pkg::MODE_READY) begin
         status = sahp_pkg::STAT_NOT_READY;
      end else if (!req_in_range) begin
         status = sahp_pkg::STAT_RANGE;
      end else begin
         status    = sahp_pkg::STAT_ACCEPTED;
         dir_in    = (req.target_position < pos_ff);
         target_in = req.target_position;
         en_in     = !req_same;
         evt       = req_same ? sahp_pkg::EVT_TARGET : sahp_pkg::EVT_NONE;
      end
   end

   always_comb begin
      result.step_pulse     = pulse;
      result.step_direction = dir_in;
      result.driver_enable  = en_in;
      result.position       = pos_in;
      result.axis_mode      = mode_in;
      result.switch_stable  = level_next;
      result.request_status = status;
      result.motion_event   = evt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sahp_pkg::MODE_SEEK;
         pos_ff    <= '0;
         target_ff <= '0;
         dir_ff    <= 1'b0;
         en_ff     <= 1'b1;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         target_ff <= target_in;
         dir_ff    <= dir_in;
         en_ff     <= en_in;
      end
   end

endmodule

FILE: hdl/stepper_axis_homing_positioner.sv
// Stepper axis homing positioner, top level: config registers, handshake, result register.
// The result word is registered and valid in the cycle after its request word is accepted.
// Throughput: one word per cycle; the single result register stalls the request
// side only while a held result is itself stalled.
// Reset (synchronous): axis seeks home, position 0, driver enabled, travel 2800, debounce 3.
// Depends on sahp_pkg, sahp_debounce, sahp_axis.
module stepper_axis_homing_positioner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sahp_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sahp_pkg::rsp_type             rsp_payload,
   input  logic                          csr_write_en,
   input  logic [0:0]                    csr_index,
   input  logic [sahp_pkg::POS_BITS-1:0] csr_write_data
);

   logic [sahp_pkg::POS_BITS-1:0] travel_ff;
   logic [sahp_pkg::DBN_BITS-1:0] debounce_ff;
   logic                          rsp_valid_ff;
   sahp_pkg::rsp_type             rsp_ff;
   sahp_pkg::rsp_type             result;
   logic                          accept;
   logic                          level_next;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         travel_ff   <= sahp_pkg::TRAVEL_RESET;
         debounce_ff <= sahp_pkg::DEBOUNCE_RESET;
      end else if (csr_write_en) begin
         unique case (sahp_pkg::csr_index_type'(csr_index))
            sahp_pkg::CSR_TRAVEL:   travel_ff   <= csr_write_data;
            sahp_pkg::CSR_DEBOUNCE: debounce_ff <= csr_write_data[sahp_pkg::DBN_BITS-1:0];
            default:                travel_ff   <= travel_ff;
         endcase
      end
   end

   sahp_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .sample         (accept && req_payload.command == sahp_pkg::CMD_TICK),
      .raw_level      (req_payload.switch_level),
      .debounce_ticks (debounce_ff),
      .level_next     (level_next)
   );

   sahp_axis u_axis (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_payload),
      .level_next   (level_next),
      .travel_steps (travel_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/sahp_checker.sv
// Port-level checker for the stepper axis homing positioner, bound to the top level.
// Depends on sahp_pkg.
module sahp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input sahp_pkg::rsp_type             rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result word changed");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request side stalled with no result pending");

   a_request_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.request_status != sahp_pkg::STAT_NONE
         |-> !rsp_payload.step_pulse)
      else $error("move request produced a step");

   a_stop_disables: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.motion_event != sahp_pkg::EVT_NONE
         |-> !rsp_payload.driver_enable && rsp_payload.axis_mode == sahp_pkg::MODE_READY)
      else $error("motion stop left the driver on or axis not ready");

   a_moving_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.axis_mode == sahp_pkg::MODE_MOVING
         |-> rsp_payload.driver_enable)
      else $error("moving axis with driver disabled");

endmodule

bind stepper_axis_homing_positioner sahp_checker u_checker (.*);
